>>> hw/rtl/pls_pkg.sv
// Shared types and constants for the positional list store.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  // Number of slots in the list; the length and position fields are sized for it.
  localparam int DEPTH = 16;

  localparam int REQ_W    = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  // Index and count width inside the cell row; the position field covers every slot
  // and the full count.
  localparam int IDX_W = POS_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_INS_POS  = 3'd2,
    REQ_REM_HEAD = 3'd3,
    REQ_REM_TAIL = 3'd4,
    REQ_REM_POS  = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Per-request command broadcast to every cell.
  typedef struct packed {
    logic             ins;    // open a gap at where and load the new value
    logic             rem;    // close the gap at where
    logic [IDX_W-1:0] where;  // target slot
  } pls_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/pls_ctrl.sv
// Request decode: target slot, status and the command for the cell row.
`timescale 1ns / 1ps
`default_nettype none

module pls_ctrl
  import pls_pkg::*;
(
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic [IDX_W-1:0]    count_i,
  input  logic                fire_i,
  output pls_cmd_t            cmd_o,
  output status_e             status_o
);

  logic [IDX_W-1:0] pos_ext;
  logic [IDX_W-1:0] where;
  logic             do_ins;
  logic             do_rem;

  assign pos_ext = IDX_W'(position_i);

  always_comb begin
    where    = '0;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    status_o = ST_OK;
    unique case (req_type_i) inside
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        if (req_type_i == REQ_INS_HEAD) begin
          where = '0;
        end else if (req_type_i == REQ_INS_TAIL) begin
          where = count_i;
        end else begin
          where = pos_ext;
        end
        if (where > count_i) begin
          status_o = ST_BADPOS;
        end else if (count_i >= IDX_W'(DEPTH)) begin
          status_o = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      REQ_REM_HEAD, REQ_REM_TAIL, REQ_REM_POS: begin
        if (req_type_i == REQ_REM_HEAD) begin
          where = '0;
        end else if (req_type_i == REQ_REM_TAIL) begin
          where = count_i - IDX_W'(1);
        end else begin
          where = pos_ext;
        end
        if (count_i == '0) begin
          status_o = ST_EMPTY;
        end else if (where >= count_i) begin
          status_o = ST_BADPOS;
        end else begin
          do_rem = 1'b1;
        end
      end
      default: begin
        status_o = ST_BADPOS;
      end
    endcase
  end

  assign cmd_o.ins   = do_ins & fire_i;
  assign cmd_o.rem   = do_rem & fire_i;
  assign cmd_o.where = where;

endmodule

`default_nettype wire

>>> hw/rtl/pls_cell.sv
// One slot of the list: holds, loads, or shifts from a neighbor.
`timescale 1ns / 1ps
`default_nettype none

module pls_cell
  import pls_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk_i,
  input  pls_cmd_t         cmd_i,
  input  logic [VAL_W-1:0] value_i,
  input  logic [VAL_W-1:0] left_i,   // neighbor at IDX-1
  input  logic [VAL_W-1:0] right_i,  // neighbor at IDX+1
  output logic [VAL_W-1:0] data_o,
  output logic [VAL_W-1:0] tap_o     // own word when it is the one removed, else zero
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [VAL_W-1:0] data_q;
  logic [VAL_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (MyIdx > cmd_i.where) begin
        data_d = left_i;
      end else if (MyIdx == cmd_i.where) begin
        data_d = value_i;
      end
    end else if (cmd_i.rem && (MyIdx >= cmd_i.where)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tap_o  = (cmd_i.rem && (MyIdx == cmd_i.where)) ? data_q : '0;

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_store.sv
// Top level: bounded ordered list built as a row of shifting cells.
// A result beat appears on the master side in the cycle after its request is taken.
// Throughput: one request per cycle; every cell decides shift/hold/load in the same cycle.
// The only stall comes from the single output register when the consumer holds tready low.
// Reset (rst_ni low, async) empties the list and drops the output beat; slot contents
// are not cleared, since only slots below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store
  import pls_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [4:0] position, [36:5] value, [39:37] zero
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] req_type
  // result side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] removed_value, [36:32] length, [39:37] zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int CntW = $clog2(DEPTH + 1);

  // Fill count
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  count_d;
  logic [IDX_W-1:0] count_ext;
  logic [IDX_W-1:0] count_nxt;

  // Request decode
  logic             in_fire;
  pls_cmd_t         cmd;
  status_e          status;

  // Cell row
  logic [VAL_W-1:0] cell_data [DEPTH];
  logic [VAL_W-1:0] cell_tap  [DEPTH];
  logic [VAL_W-1:0] removed;

  // Output register
  logic             out_vld_q;
  logic             out_vld_d;
  logic [VAL_W-1:0] out_removed_q;
  status_e          out_status_q;
  logic [LEN_W-1:0] out_len_q;

  // A new beat is taken whenever the output register is empty or draining this cycle.
  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign count_ext = IDX_W'(count_q);

  pls_ctrl u_ctrl (
    .req_type_i (s_axis_tuser_i),
    .position_i (s_axis_tdata_i[4:0]),
    .count_i    (count_ext),
    .fire_i     (in_fire),
    .cmd_o      (cmd),
    .status_o   (status)
  );

  // Row of cells; ends see zeros from the missing neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    pls_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .value_i (s_axis_tdata_i[36:5]),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .tap_o   (cell_tap[g])
    );
  end

  // At most one tap is nonzero, so an OR collects the removed word.
  always_comb begin
    removed = '0;
    for (int i = 0; i < DEPTH; i++) begin
      removed = removed | cell_tap[i];
    end
  end

  always_comb begin
    count_nxt = count_ext;
    if (cmd.ins) begin
      count_nxt = count_ext + IDX_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_ext - IDX_W'(1);
    end
  end

  assign count_d   = CntW'(count_nxt);
  assign out_vld_d = in_fire || (out_vld_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Result payload, loaded with each accepted request.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_removed_q <= removed;
      out_status_q  <= status;
      out_len_q     <= count_nxt[LEN_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_len_q, out_removed_q};
  assign m_axis_tuser_o  = out_status_q;

  // Checks

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_ext <= IDX_W'(DEPTH))
    else $error("fill count above depth");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (status != ST_OK) |=> $stable(count_q))
    else $error("failed request changed the fill count");

  a_remove_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rem |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("removal did not shrink the list by one");

  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_status_q != ST_OK) |-> (out_removed_q == '0))
    else $error("nonzero removed value on a failed request");

endmodule

`default_nettype wire
